// ===== sv/ptw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

  localparam int TABLE_SLOTS_DEFAULT = 64;

  localparam int VA_W        = 48;
  localparam int ENTRY_W     = 64;
  localparam int IDX_W       = 9;
  localparam int SLOT_IN_W   = 6;
  localparam int BASE_W      = 36;
  localparam int FRAME_W     = 40;
  localparam int FRAME_LSB   = 12;
  localparam int LEVEL_W     = 2;
  localparam int SLOT_EXT_W  = 13;  // holds any slot count up to 4096
  localparam int PRESENT_BIT = 0;
  localparam int LARGE_BIT   = 7;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_WRITE     = 1'b1;

  localparam logic [LEVEL_W-1:0] LEVEL_4K   = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_2M   = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_1G   = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_512G = 2'd3;

  typedef struct packed {
    logic [ENTRY_W-1:0] phys_addr;
    logic               not_mapped;
    logic [LEVEL_W-1:0] page_level;
  } ptw_result_t;

  // Low 12+9*level bits set: page offset for a page at that level.
  function automatic logic [ENTRY_W-1:0] page_mask(input logic [LEVEL_W-1:0] level);
    logic [ENTRY_W-1:0] m;
    begin
      unique case (level)
        LEVEL_4K:   m = 64'h0000_0000_0000_0fff;
        LEVEL_2M:   m = 64'h0000_0000_001f_ffff;
        LEVEL_1G:   m = 64'h0000_0000_3fff_ffff;
        LEVEL_512G: m = 64'h0000_007f_ffff_ffff;
        default:    m = 64'h0000_0000_0000_0fff;
      endcase
      return m;
    end
  endfunction

  // Table index that a virtual address selects at a level.
  function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                 input logic [LEVEL_W-1:0] level);
    logic [IDX_W-1:0] ix;
    begin
      unique case (level)
        LEVEL_4K:   ix = va[20:12];
        LEVEL_2M:   ix = va[29:21];
        LEVEL_1G:   ix = va[38:30];
        LEVEL_512G: ix = va[47:39];
        default:    ix = va[20:12];
      endcase
      return ix;
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/ptw_table_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptw_table_mem #(
  parameter int DEPTH  = 32768,
  parameter int ADDR_W = 15
) (
  input  wire                           clk,
  input  wire                           wr_en,
  input  wire  [ADDR_W-1:0]             wr_addr,
  input  wire  [ptw_pkg::ENTRY_W-1:0]   wr_data,
  input  wire                           rd_en,
  input  wire  [ADDR_W-1:0]             rd_addr,
  output logic [ptw_pkg::ENTRY_W-1:0]   rd_data
);
  import ptw_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/ptw_walker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptw_walker #(
  parameter int TABLE_SLOTS = ptw_pkg::TABLE_SLOTS_DEFAULT,
  parameter int SLOT_W      = 6,
  parameter int ADDR_W      = 15
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              in_op,
  input  wire  [ptw_pkg::VA_W-1:0]         in_vaddr,
  input  wire  [ptw_pkg::SLOT_IN_W-1:0]    in_slot,
  input  wire  [ptw_pkg::IDX_W-1:0]        in_entry_index,
  input  wire  [ptw_pkg::ENTRY_W-1:0]      in_entry_value,
  input  wire  [ptw_pkg::BASE_W-1:0]       base_frame,
  input  wire                              out_free,
  output logic                             res_valid,
  output ptw_pkg::ptw_result_t             res,
  output logic                             mem_wr_en,
  output logic [ADDR_W-1:0]                mem_wr_addr,
  output logic [ptw_pkg::ENTRY_W-1:0]      mem_wr_data,
  output logic                             mem_rd_en,
  output logic [ADDR_W-1:0]                mem_rd_addr,
  input  wire  [ptw_pkg::ENTRY_W-1:0]      mem_rd_data
);
  import ptw_pkg::*;

  localparam int DEPTH = TABLE_SLOTS * (1 << IDX_W);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_WDONE = 2'd3;

  logic [1:0]         state, state_next;
  logic [LEVEL_W-1:0] level, level_next;
  logic [VA_W-1:0]    va, va_next;
  logic [ADDR_W-1:0]  clear_cnt, clear_cnt_next;

  logic               ent_present, ent_large, frame_bad, walk_bad, walk_stop;
  logic [FRAME_W-1:0] frame;
  logic [FRAME_W:0]   frame_rel;
  logic [ENTRY_W-1:0] mask;
  logic [SLOT_EXT_W-1:0] slot_ext;
  logic               slot_ok;
  logic               accept;

  assign accept      = in_valid && in_ready;
  assign ent_present = mem_rd_data[PRESENT_BIT];
  assign ent_large   = mem_rd_data[LARGE_BIT];
  assign frame       = mem_rd_data[FRAME_LSB +: FRAME_W];
  assign frame_rel   = {1'b0, frame} - (FRAME_W + 1)'(base_frame);
  assign frame_bad   = frame_rel[FRAME_W] ||
                       (frame_rel[FRAME_W-1:0] >= FRAME_W'(TABLE_SLOTS));
  assign walk_bad    = !ent_present ||
                       (!ent_large && (level != LEVEL_4K) && frame_bad);
  assign walk_stop   = walk_bad || ent_large || (level == LEVEL_4K);
  assign mask        = page_mask(level);
  assign slot_ext    = SLOT_EXT_W'(in_slot);
  assign slot_ok     = slot_ext < SLOT_EXT_W'(TABLE_SLOTS);

  always_comb begin
    state_next     = state;
    level_next     = level;
    va_next        = va;
    clear_cnt_next = clear_cnt;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    res            = '0;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = clear_cnt;
    mem_wr_data    = '0;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = {{SLOT_W{1'b0}}, va_index(in_vaddr, LEVEL_512G)};
    unique case (state)
      ST_CLEAR: begin
        mem_wr_en      = 1'b1;
        clear_cnt_next = clear_cnt + 1'b1;
        if (clear_cnt == ADDR_W'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (in_op == OP_WRITE) begin
            mem_wr_en   = slot_ok;
            mem_wr_addr = {slot_ext[SLOT_W-1:0], in_entry_index};
            mem_wr_data = in_entry_value;
            state_next  = ST_WDONE;
          end else begin
            mem_rd_en  = 1'b1;
            va_next    = in_vaddr;
            level_next = LEVEL_512G;
            state_next = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (walk_bad) begin
          res.phys_addr  = '1;
          res.not_mapped = 1'b1;
        end else begin
          res.phys_addr  = (mem_rd_data & ~mask) | (ENTRY_W'(va) & mask);
          res.not_mapped = 1'b0;
        end
        res.page_level = level;
        if (!walk_stop) begin
          // Descend: fetch the entry of the next table.
          mem_rd_en   = 1'b1;
          mem_rd_addr = {frame_rel[SLOT_W-1:0], va_index(va, level - 1'b1)};
          level_next  = level - 1'b1;
        end else if (out_free) begin
          res_valid  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_WDONE: begin
        if (out_free) begin
          res_valid  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clear_cnt <= '0;
    end else begin
      state     <= state_next;
      clear_cnt <= clear_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    level <= level_next;
    va    <= va_next;
  end

endmodule

`default_nettype wire

// ===== sv/four_level_page_table_walk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequencing: a write is accepted in IDLE and offers its result from WDONE; a translate is accepted
//   in IDLE and offers its result from WALK, after one table memory read per level walked.
// Neither takes a new transaction until its result is handed to the output register, and the
//   single read port of the table memory, read once per level in sequence, sets the pace.
// Reset: rst clears control state and base_frame, then a clearing pass writes zero
//   to all TABLE_SLOTS*512 table entries with s_axis_tready low.
module four_level_page_table_walk #(
  parameter int TABLE_SLOTS = ptw_pkg::TABLE_SLOTS_DEFAULT
) (
  input  wire                              clk,
  input  wire                              rst,
  // Table base register.
  input  wire                              cfg_wr_en,
  input  wire  [ptw_pkg::BASE_W-1:0]       cfg_wr_data,
  // Input stream.
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata, low bit up: vaddr[47:0], slot[53:48], entry_index[62:54],
  // entry_value[126:63], zero pad[127]
  input  wire  [127:0]                     s_axis_tdata,
  // tuser: op[0]
  input  wire                              s_axis_tuser,
  // Result stream.
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // tdata, low bit up: phys_addr[63:0], page_level[65:64], zero pad[71:66]
  output logic [71:0]                      m_axis_tdata,
  // tuser: not_mapped[0]
  output logic                             m_axis_tuser
);
  import ptw_pkg::*;

  // Table memory geometry: slot number above a 9-bit entry index.
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int DEPTH  = TABLE_SLOTS * (1 << IDX_W);
  localparam int ADDR_W = SLOT_W + IDX_W;

  logic [BASE_W-1:0]  base_frame;
  logic               out_free;
  logic               res_valid;
  ptw_result_t        res;
  ptw_result_t        out_res;
  logic               mem_wr_en, mem_rd_en;
  logic [ADDR_W-1:0]  mem_wr_addr, mem_rd_addr;
  logic [ENTRY_W-1:0] mem_wr_data, mem_rd_data;

  // Base frame register: write it only while no transaction is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_frame <= '0;
    end else if (cfg_wr_en) begin
      base_frame <= cfg_wr_data;
    end
  end

  // The walker sequences the clearing pass, entry writes and the level-by-level walk.
  ptw_walker #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SLOT_W      (SLOT_W),
    .ADDR_W      (ADDR_W)
  ) u_walker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_op          (s_axis_tuser),
    .in_vaddr       (s_axis_tdata[47:0]),
    .in_slot        (s_axis_tdata[53:48]),
    .in_entry_index (s_axis_tdata[62:54]),
    .in_entry_value (s_axis_tdata[126:63]),
    .base_frame     (base_frame),
    .out_free       (out_free),
    .res_valid      (res_valid),
    .res            (res),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data)
  );

  // One write port, one registered read port.
  ptw_table_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output register: the walker loads it only when it is empty or being drained, so a
  // finished transaction can wait here while the next one is accepted and walked.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {6'd0, out_res.page_level, out_res.phys_addr};
  assign m_axis_tuser = out_res.not_mapped;

  // The walker never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_free)
    else $error("result pushed into a full output register");

  // The clearing pass keeps the input closed right after reset.
  a_clear_closed: assert property (@(posedge clk)
    $past(rst) |-> !s_axis_tready)
    else $error("input open during clearing pass");

  // An unmapped result always carries the all-ones address.
  a_unmapped_ones: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (&m_axis_tdata[63:0]))
    else $error("unmapped result without all-ones address");

  // A stalled result stays in place until taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("output register changed while stalled");

endmodule

`default_nettype wire

// ===== sim/page_walk_checker.sv =====
`timescale 1ns / 1ps
module page_walk_checker #(
  parameter int TABLE_SLOTS = ptw_pkg::TABLE_SLOTS_DEFAULT
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          cfg_wr_en,
  input  wire [35:0]   cfg_wr_data,
  input  wire          s_axis_tvalid,
  input  wire          s_axis_tready,
  input  wire [127:0]  s_axis_tdata,
  input  wire          s_axis_tuser,
  input  wire          m_axis_tvalid,
  input  wire          m_axis_tready,
  input  wire [71:0]   m_axis_tdata,
  input  wire          m_axis_tuser,
  output int           fail_count,
  output int           awaited_count,
  output int           mapped_count
);
  import ptw_pkg::*;

  localparam int ENTRIES = 1 << IDX_W;

  logic [ENTRY_W-1:0] shadow_tables [TABLE_SLOTS*ENTRIES];
  logic [BASE_W-1:0]  shadow_base;
  ptw_result_t        walk_results_q [$];
  ptw_result_t        oldest;

  logic [VA_W-1:0]      in_va;
  logic [SLOT_IN_W-1:0] in_slot;
  logic [IDX_W-1:0]     in_ix;
  logic [ENTRY_W-1:0]   in_value;

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t ns: %s got %h expected %h", $time, field, got, want);
    fail_count++;
  endtask

  // Walk the shadow tables from the root slot down to the final entry.
  function automatic ptw_result_t predict_walk(input logic [VA_W-1:0] va);
    ptw_result_t        res;
    logic [ENTRY_W-1:0] ent;
    logic [ENTRY_W-1:0] offset_mask;
    logic [FRAME_W-1:0] frame;
    logic [FRAME_W-1:0] rel;
    logic [IDX_W-1:0]   ix;
    logic [LEVEL_W-1:0] lvl;
    int unsigned        cur_slot;
    bit                 missing;
    bit                 done;
    cur_slot = 0;
    lvl      = LEVEL_512G;
    missing  = 1'b0;
    done     = 1'b0;
    ent      = '0;
    while (!done) begin
      ix  = IDX_W'(va >> (FRAME_LSB + IDX_W * lvl));
      ent = shadow_tables[cur_slot * ENTRIES + ix];
      if (!ent[PRESENT_BIT]) begin
        missing = 1'b1;
        done    = 1'b1;
      end else if (lvl == LEVEL_4K || ent[LARGE_BIT]) begin
        done = 1'b1;
      end else begin
        frame = ent[FRAME_LSB +: FRAME_W];
        rel   = frame - {4'b0, shadow_base};
        if (frame < {4'b0, shadow_base} || rel >= TABLE_SLOTS) begin
          missing = 1'b1;
          done    = 1'b1;
        end else begin
          cur_slot = 32'(rel);
          lvl      = lvl - 1'b1;
        end
      end
    end
    res.page_level = lvl;
    if (missing) begin
      res.phys_addr  = '1;
      res.not_mapped = 1'b1;
    end else begin
      offset_mask    = (64'd1 << (FRAME_LSB + IDX_W * lvl)) - 64'd1;
      res.phys_addr  = (ent & ~offset_mask) | ({16'b0, va} & offset_mask);
      res.not_mapped = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (shadow_tables[i]) shadow_tables[i] = '0;
      shadow_base = '0;
      walk_results_q.delete();
      fail_count   = 0;
      mapped_count = 0;
    end else begin
      if (cfg_wr_en) shadow_base = cfg_wr_data;

      if (s_axis_tvalid && s_axis_tready) begin
        in_va    = s_axis_tdata[47:0];
        in_slot  = s_axis_tdata[53:48];
        in_ix    = s_axis_tdata[62:54];
        in_value = s_axis_tdata[126:63];
        if (s_axis_tuser == OP_WRITE) begin
          if (in_slot < TABLE_SLOTS) shadow_tables[in_slot * ENTRIES + in_ix] = in_value;
          walk_results_q.push_back('0);
        end else begin
          oldest = predict_walk(in_va);
          if (!oldest.not_mapped) mapped_count++;
          walk_results_q.push_back(oldest);
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (walk_results_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[63:0], '0);
        end else begin
          oldest = walk_results_q.pop_front();
          if (m_axis_tdata[63:0] !== oldest.phys_addr)
            report_mismatch("phys_addr", m_axis_tdata[63:0], oldest.phys_addr);
          if (m_axis_tuser !== oldest.not_mapped)
            report_mismatch("not_mapped", 64'(m_axis_tuser), 64'(oldest.not_mapped));
          if (m_axis_tdata[65:64] !== oldest.page_level)
            report_mismatch("page_level", 64'(m_axis_tdata[65:64]), 64'(oldest.page_level));
          if (m_axis_tdata[71:66] !== '0)
            report_mismatch("tdata pad", 64'(m_axis_tdata[71:66]), '0);
        end
      end
    end
    awaited_count = walk_results_q.size();
  end

endmodule

// ===== sim/tb_four_level_page_table_walk.sv =====
`timescale 1ns / 1ps
module tb_four_level_page_table_walk;
  import ptw_pkg::*;

  localparam int SLOTS        = TABLE_SLOTS_DEFAULT;
  localparam int RANDOM_ITEMS = 700;
  // Clearing pass plus roughly 800 transactions, each at the worst-case input gap,
  // walk and result stall, then taken several times over.
  localparam int CYCLE_LIMIT  = 400000;

  logic          clk;
  logic          rst;
  logic          cfg_wr_en;
  logic [35:0]   cfg_wr_data;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  // tdata, low bit up: vaddr[47:0], slot[53:48], entry_index[62:54],
  // entry_value[126:63], zero pad[127]
  logic [127:0]  s_axis_tdata;
  // tuser: op[0]
  logic          s_axis_tuser;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  // tdata, low bit up: phys_addr[63:0], page_level[65:64], zero pad[71:66]
  logic [71:0]   m_axis_tdata;
  // tuser: not_mapped[0]
  logic          m_axis_tuser;

  int fail_count;
  int awaited_count;
  int mapped_count;

  int                cycle_count = 0;
  int                items_sent = 0;
  int                writes_sent = 0;
  int                translates_sent = 0;
  int                base_settings = 1;
  logic [BASE_W-1:0] base_now = '0;
  bit                tx_calm = 1'b0;
  bit                rx_calm = 1'b0;

  four_level_page_table_walk dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  page_walk_checker walk_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .awaited_count (awaited_count),
    .mapped_count  (mapped_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("four_level_page_table_walk verification failed");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before each transaction,
  // except during calm stretches where ready stays high.
  initial begin : result_sink
    int unsigned stall;
    m_axis_tready = 1'b0;
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Offer one transaction after a random gap; return at the falling edge
  // after it is taken, with tvalid still high so back-to-back items flow.
  task automatic send_item(input logic op, input logic [VA_W-1:0] va,
                           input logic [SLOT_IN_W-1:0] slot, input logic [IDX_W-1:0] ix,
                           input logic [ENTRY_W-1:0] value);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, value, ix, slot, va};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (op == OP_WRITE) writes_sent++;
    else translates_sent++;
  endtask

  // Unused fields of each item carry random bits so every input bit toggles.
  task automatic write_entry(input int unsigned slot, input int unsigned ix,
                             input logic [ENTRY_W-1:0] value);
    send_item(OP_WRITE, VA_W'({$urandom, $urandom}), slot[SLOT_IN_W-1:0], ix[IDX_W-1:0],
              value);
  endtask

  task automatic translate(input logic [VA_W-1:0] va);
    send_item(OP_TRANSLATE, va, SLOT_IN_W'($urandom), IDX_W'($urandom),
              {$urandom, $urandom});
  endtask

  // Drop tvalid and hold off until every result has come back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (awaited_count != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Only called after settle, so the walker is idle.
  task automatic set_base(input logic [BASE_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    base_now = value;
    base_settings++;
  endtask

  function automatic logic [VA_W-1:0] va_of(input int i3, input int i2, input int i1,
                                            input int i0, input int off);
    return {i3[8:0], i2[8:0], i1[8:0], i0[8:0], off[11:0]};
  endfunction

  // Present, non-large entry pointing at the table held in the given slot;
  // flag bits and the no-execute region are random.
  function automatic logic [ENTRY_W-1:0] table_link(input int unsigned child);
    logic [ENTRY_W-1:0] value;
    value = {$urandom, $urandom};
    value[FRAME_LSB +: FRAME_W] = {4'b0, base_now} + child;
    value[PRESENT_BIT] = 1'b1;
    value[LARGE_BIT]   = 1'b0;
    return value;
  endfunction

  // Frame just past the held slots, just below the base, or anywhere.
  function automatic logic [FRAME_W-1:0] stray_frame();
    logic [FRAME_W-1:0] frame;
    case ($urandom_range(0, 2))
      0: frame = {4'b0, base_now} + SLOTS + $urandom_range(0, 3);
      1: frame = (base_now == 0) ? FRAME_W'({$urandom, $urandom})
                                 : {4'b0, base_now} - 1 - $urandom_range(0, 1);
      default: frame = FRAME_W'({$urandom, $urandom});
    endcase
    return frame;
  endfunction

  // Build a full chain of tables down to a leaf at a random level, then
  // translate through it. A broken chain has one link absent or pointing
  // outside the held slots.
  task automatic build_walk(input bit broken);
    logic [VA_W-1:0]    va;
    logic [VA_W-1:0]    offset_mask;
    logic [ENTRY_W-1:0] value;
    logic [IDX_W-1:0]   ix;
    int                 leaf;
    int                 cut;
    int                 lvl;
    int unsigned        here;
    int unsigned        child;
    va   = VA_W'({$urandom, $urandom});
    leaf = $urandom_range(0, 3);
    cut  = broken ? $urandom_range(leaf, 3) : -1;
    here = 0;
    for (lvl = 3; lvl >= leaf; lvl--) begin
      if (lvl == leaf) begin
        value = {$urandom, $urandom};
        value[PRESENT_BIT] = (lvl != cut);
        if (lvl != 0) value[LARGE_BIT] = 1'b1;
        child = here;
      end else begin
        // Lean on the first and last slot to hit the range boundaries.
        if ($urandom_range(0, 3) == 0) child = $urandom_range(0, 1) ? SLOTS - 1 : 0;
        else child = $urandom_range(1, SLOTS - 2);
        value = table_link(child);
        if (lvl == cut) begin
          if ($urandom_range(0, 1)) value[PRESENT_BIT] = 1'b0;
          else value[FRAME_LSB +: FRAME_W] = stray_frame();
        end
      end
      ix = IDX_W'(va >> (FRAME_LSB + IDX_W * lvl));
      write_entry(here, 32'(ix), value);
      here = child;
    end
    translate(va);
    // Revisit the same page at other offsets.
    offset_mask = (48'd1 << (FRAME_LSB + IDX_W * leaf)) - 48'd1;
    repeat ($urandom_range(0, 2))
      translate(VA_W'((va & ~offset_mask) | ({$urandom, $urandom} & offset_mask)));
  endtask

  task automatic random_phase(input int quota);
    int start;
    int pick;
    start = items_sent;
    while (items_sent - start < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) build_walk(1'b0);
      else if (pick < 80) build_walk(1'b1);
      else if (pick < 90)
        write_entry($urandom_range(0, SLOTS - 1), $urandom_range(0, 511), {$urandom, $urandom});
      else translate(VA_W'({$urandom, $urandom}));
      // Switch between busy and calm stretches on each side now and then.
      if ($urandom_range(0, 15) == 0) begin
        tx_calm = ($urandom_range(0, 2) == 0);
        rx_calm = ($urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 49) == 0) settle();
    end
    settle();
  endtask

  initial begin : stimulus
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_TRANSLATE;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed part, base frame at its reset value of zero.
    // Empty tables: absent at the root.
    translate(va_of(0, 0, 0, 0, 0));
    translate('1);
    // Large page honored at the root, high flags kept.
    write_entry(0, 0, 64'hfff0_0000_0000_0081);
    translate(va_of(0, 511, 511, 511, 12'hfff));
    // Link with no-execute set, then a 1 GiB page.
    write_entry(0, 1, 64'h8000_0000_0000_1001);
    write_entry(1, 0, 64'h0000_000f_c000_0083);
    translate(va_of(1, 0, 3, 4, 12'h123));
    // 2 MiB page.
    write_entry(1, 1, 64'h0000_0000_0000_2067);
    write_entry(2, 0, 64'h0000_0001_23e0_00e1);
    translate(va_of(1, 1, 0, 77, 12'habc));
    // 4 KiB page whose large-page bit is set but means nothing at the last level.
    write_entry(2, 1, 64'h0000_0000_0000_3003);
    write_entry(3, 5, 64'h7ff0_00ab_cdef_f0ff);
    translate(va_of(1, 1, 1, 5, 12'hfff));
    // Absent entry at the last level.
    translate(va_of(1, 1, 1, 6, 0));
    // Frame one past the held slots.
    write_entry(1, 2, 64'h0000_0000_0004_0001);
    translate(va_of(1, 2, 0, 0, 0));
    // Last held slot, all-ones leaf.
    write_entry(2, 2, 64'h0000_0000_0003_f001);
    write_entry(63, 511, '1);
    translate(va_of(1, 1, 2, 511, 0));
    // All-zero write, and an all-ones root entry under an all-ones address.
    write_entry(63, 0, '0);
    write_entry(0, 511, '1);
    translate('1);
    settle();

    // Move the base up: the old root link now names a frame below it.
    set_base(36'h10);
    translate(va_of(1, 0, 0, 0, 0));
    random_phase(RANDOM_ITEMS / 4);

    set_base('1);
    random_phase(RANDOM_ITEMS / 4);

    set_base({4'($urandom_range(0, 15)), $urandom});
    random_phase(RANDOM_ITEMS / 4);

    set_base('0);
    random_phase(RANDOM_ITEMS / 4);

    // Let any late result surface before the verdict.
    repeat (16) @(posedge clk);
    $display("run covered %0d table writes and %0d translations over %0d base settings",
             writes_sent, translates_sent, base_settings);
    $display("%0d translations reached a mapped page, %0d field mismatches",
             mapped_count, fail_count);
    if (fail_count == 0 && awaited_count == 0) begin
      $display("four_level_page_table_walk verification clean");
    end else begin
      $display("four_level_page_table_walk verification failed");
    end
    $finish;
  end

endmodule
